// ===== src/dpd_pkg.sv =====
// Shared constants and helpers for the debug packet deframer.
`default_nettype none

package dpd_pkg;

  // Payload limit and the counter width that holds it
  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned CNT_W       = $clog2(MAX_PAYLOAD + 1);

  // Result field widths
  localparam int unsigned KIND_W = 3;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned PKT_W  = 32;

  // Framing characters
  localparam logic [7:0] CH_START  = 8'h24;  // '$'
  localparam logic [7:0] CH_END    = 8'h23;  // '#'
  localparam logic [7:0] CH_ESCAPE = 8'h7D;  // '}'
  localparam logic [7:0] CH_BREAK  = 8'h03;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // Event kinds reported on the result channel
  localparam logic [KIND_W-1:0] EV_START = 3'd0;
  localparam logic [KIND_W-1:0] EV_BYTE  = 3'd1;
  localparam logic [KIND_W-1:0] EV_GOOD  = 3'd2;
  localparam logic [KIND_W-1:0] EV_BAD   = 3'd3;
  localparam logic [KIND_W-1:0] EV_BREAK = 3'd4;

  // Decode one ASCII hex digit; anything else reads as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      case (c) inside
        [8'h30:8'h39]: d = c - 8'h30;
        [8'h61:8'h66]: d = c - 8'h61 + 8'd10;
        [8'h41:8'h46]: d = c - 8'h41 + 8'd10;
        default:       d = 8'h00;
      endcase
      hex_value = d[3:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/dpd_parse.sv =====
// Framing state machine with the registered result stage.
`default_nettype none

module dpd_parse (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [7:0]                  rx_byte,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic [dpd_pkg::KIND_W-1:0]       out_event_kind,
  output logic [7:0]                       out_payload_byte,
  output logic [dpd_pkg::POS_W-1:0]        out_byte_position,
  output logic [dpd_pkg::LEN_W-1:0]        out_payload_length,
  output logic [7:0]                       out_computed_sum,
  output logic [7:0]                       out_received_sum,
  output logic [dpd_pkg::PKT_W-1:0]        out_packet_number
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_DATA = 3'd1,
    PH_ESC  = 3'd2,
    PH_CS1  = 3'd3,
    PH_CS2  = 3'd4
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [7:0]                    sum_r, sum_nxt;
  logic [7:0]                    hi_r, hi_nxt;
  logic [dpd_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [dpd_pkg::PKT_W-1:0]     gcnt_r, gcnt_nxt;

  logic                          out_valid_r;
  logic [dpd_pkg::KIND_W-1:0]    kind_r, kind_nxt;
  logic [7:0]                    pbyte_r, pbyte_nxt;
  logic [dpd_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [dpd_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [7:0]                    csum_r, csum_nxt;
  logic [7:0]                    rsum_r, rsum_nxt;
  logic [dpd_pkg::PKT_W-1:0]     pnum_r, pnum_nxt;
  logic                          emit;

  logic [7:0]                    store_val;
  logic                          store_en;
  logic                          full;
  logic [7:0]                    rx_sum;

  assign full   = (cnt_r >= dpd_pkg::CNT_W'(dpd_pkg::MAX_PAYLOAD));
  assign rx_sum = hi_r + {4'h0, dpd_pkg::hex_value(rx_byte)};

  // Work out next state and the result for one received byte
  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    hi_nxt    = hi_r;
    cnt_nxt   = cnt_r;
    gcnt_nxt  = gcnt_r;
    emit      = 1'b0;
    kind_nxt  = dpd_pkg::EV_START;
    pbyte_nxt = 8'h00;
    pos_nxt   = '0;
    len_nxt   = '0;
    csum_nxt  = 8'h00;
    rsum_nxt  = 8'h00;
    pnum_nxt  = '0;
    store_en  = 1'b0;
    store_val = rx_byte;
    case (phase_r)
      PH_DATA: begin
        if (rx_byte == dpd_pkg::CH_ESCAPE) begin
          sum_nxt   = sum_r + rx_byte;
          phase_nxt = PH_ESC;
        end else if (rx_byte == dpd_pkg::CH_START) begin
          sum_nxt   = 8'h00;
          cnt_nxt   = '0;
          phase_nxt = PH_DATA;
          emit      = 1'b1;
          kind_nxt  = dpd_pkg::EV_START;
        end else if (rx_byte == dpd_pkg::CH_END) begin
          phase_nxt = PH_CS1;
        end else begin
          sum_nxt  = sum_r + rx_byte;
          store_en = 1'b1;
        end
      end
      PH_ESC: begin
        phase_nxt = PH_DATA;
        sum_nxt   = sum_r + rx_byte;
        store_en  = 1'b1;
        store_val = rx_byte ^ dpd_pkg::ESC_XOR;
      end
      PH_CS1: begin
        hi_nxt    = {dpd_pkg::hex_value(rx_byte), 4'h0};
        phase_nxt = PH_CS2;
      end
      PH_CS2: begin
        phase_nxt = PH_HUNT;
        emit      = 1'b1;
        len_nxt   = dpd_pkg::LEN_W'(cnt_r);
        csum_nxt  = sum_r;
        rsum_nxt  = rx_sum;
        if (rx_sum == sum_r) begin
          gcnt_nxt = gcnt_r + 1'b1;
          kind_nxt = dpd_pkg::EV_GOOD;
          pnum_nxt = gcnt_r + 1'b1;
        end else begin
          kind_nxt = dpd_pkg::EV_BAD;
        end
      end
      default: begin
        // hunt, and any unused phase code
        phase_nxt = PH_HUNT;
        if (rx_byte == dpd_pkg::CH_START) begin
          sum_nxt   = 8'h00;
          cnt_nxt   = '0;
          phase_nxt = PH_DATA;
          emit      = 1'b1;
          kind_nxt  = dpd_pkg::EV_START;
        end else if (rx_byte == dpd_pkg::CH_BREAK) begin
          emit     = 1'b1;
          kind_nxt = dpd_pkg::EV_BREAK;
        end
      end
    endcase

    // Store a payload byte, or drop it once the limit is reached
    if (store_en) begin
      if (full) begin
        cnt_nxt = dpd_pkg::CNT_W'(dpd_pkg::MAX_PAYLOAD);
      end else begin
        emit      = 1'b1;
        kind_nxt  = dpd_pkg::EV_BYTE;
        pbyte_nxt = store_val;
        pos_nxt   = cnt_r[dpd_pkg::POS_W-1:0];
        cnt_nxt   = cnt_r + 1'b1;
      end
    end
  end

  // Hold parse state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      sum_r       <= 8'h00;
      hi_r        <= 8'h00;
      cnt_r       <= '0;
      gcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt;
        sum_r   <= sum_nxt;
        hi_r    <= hi_nxt;
        cnt_r   <= cnt_nxt;
        gcnt_r  <= gcnt_nxt;
      end
      if (step && emit) begin
        out_valid_r <= 1'b1;
        kind_r      <= kind_nxt;
        pbyte_r     <= pbyte_nxt;
        pos_r       <= pos_nxt;
        len_r       <= len_nxt;
        csum_r      <= csum_nxt;
        rsum_r      <= rsum_nxt;
        pnum_r      <= pnum_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = kind_r;
  assign out_payload_byte   = pbyte_r;
  assign out_byte_position  = pos_r;
  assign out_payload_length = len_r;
  assign out_computed_sum   = csum_r;
  assign out_received_sum   = rsum_r;
  assign out_packet_number  = pnum_r;

`ifndef SYNTH
  // Never advance over a result that is still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !step)
    else $error("byte processed while result stalled");

  // Stored count stays within the payload limit
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dpd_pkg::CNT_W'(dpd_pkg::MAX_PAYLOAD))
    else $error("stored count past payload limit");

  // A good end carries matching sums
  a_good_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == dpd_pkg::EV_GOOD |-> rsum_r == csum_r)
    else $error("good end with mismatched checksum");

  // A good end reports the current good-packet count
  a_good_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == dpd_pkg::EV_GOOD |-> pnum_r == gcnt_r)
    else $error("packet number out of step with count");
`endif

endmodule

`default_nettype wire

// ===== src/debug_packet_deframer.sv =====
// Top level of the debug packet deframer: input register and handshake.
`default_nettype none

// Deframes $payload#hh debug-link packets one received byte per request.
// Each accepted byte is held in an input register and, when it advances,
// goes through the framing state machine into the result register. A new
// byte is taken every cycle unless a stalled result holds the input
// register. Reported events: packet start, payload byte (with its position),
// good or bad checksum end (length, computed and received sums, and for a
// good end the running count of good packets) and break. Escape markers,
// '#' and the first checksum digit consume a byte without a result, as do
// bytes past the payload limit.
module debug_packet_deframer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [dpd_pkg::KIND_W-1:0]       out_event_kind,
  output logic [7:0]                       out_payload_byte,
  output logic [dpd_pkg::POS_W-1:0]        out_byte_position,
  output logic [dpd_pkg::LEN_W-1:0]        out_payload_length,
  output logic [7:0]                       out_computed_sum,
  output logic [7:0]                       out_received_sum,
  output logic [dpd_pkg::PKT_W-1:0]        out_packet_number
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       step;

  // Advance the held byte when the result register is free or draining
  assign step     = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !step;

  // Capture an incoming request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  dpd_parse u_parse (
    .clk                (clk),
    .rst_n              (rst_n),
    .step               (step),
    .rx_byte            (s1_byte_r),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_event_kind     (out_event_kind),
    .out_payload_byte   (out_payload_byte),
    .out_byte_position  (out_byte_position),
    .out_payload_length (out_payload_length),
    .out_computed_sum   (out_computed_sum),
    .out_received_sum   (out_received_sum),
    .out_packet_number  (out_packet_number)
  );

endmodule

`default_nettype wire

// ===== test/debug_packet_deframer_tb.sv =====
// Self-checking testbench for the debug packet deframer: framed byte streams against a predictor.
`default_nettype none

module debug_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_BYTES = 40;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [2:0] {PH_HUNT, PH_DATA, PH_ESC, PH_CS1, PH_CS2} deframe_phase_t;

  typedef struct {
    logic [dpd_pkg::KIND_W-1:0] kind;
    logic [7:0]                 data;
    logic [dpd_pkg::POS_W-1:0]  pos;
    logic [dpd_pkg::LEN_W-1:0]  len;
    logic [7:0]                 csum;
    logic [7:0]                 rsum;
    logic [dpd_pkg::PKT_W-1:0]  pnum;
  } frame_event_t;

  // Tracks the framing state of the byte stream and holds the events still owed
  class deframe_tracker;
    deframe_phase_t            phase;
    logic [7:0]                sum;
    logic [7:0]                hi_nibble;
    int unsigned               stored;
    logic [dpd_pkg::PKT_W-1:0] good_count;
    frame_event_t              owed_events[$];
    int unsigned               failures;
    int unsigned               used_bytes;

    function new();
      phase = PH_HUNT;
      sum = 8'h00;
      hi_nibble = 8'h00;
      stored = 0;
      good_count = '0;
      failures = 0;
      used_bytes = 0;
    endfunction

    function logic [3:0] digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
      return 4'h0;
    endfunction

    // Open a fresh packet: clear sum and count
    function void open_packet(inout frame_event_t ev);
      sum = 8'h00;
      stored = 0;
      phase = PH_DATA;
      ev.kind = dpd_pkg::EV_START;
    endfunction

    // Store one payload byte unless the limit is reached
    function bit keep_payload(input logic [7:0] b, inout frame_event_t ev);
      if (stored >= dpd_pkg::MAX_PAYLOAD) begin
        stored = dpd_pkg::MAX_PAYLOAD;
        return 1'b0;
      end
      ev.kind = dpd_pkg::EV_BYTE;
      ev.data = b;
      ev.pos = stored[dpd_pkg::POS_W-1:0];
      stored++;
      return 1'b1;
    endfunction

    // Advance the predictor by one accepted byte request
    function void take_byte(input logic [7:0] c);
      frame_event_t ev;
      logic [7:0]   rx;
      bit           made;
      ev = '{default: 0};
      made = 1'b0;
      if (!(phase == PH_HUNT && c != dpd_pkg::CH_START && c != dpd_pkg::CH_BREAK))
        used_bytes++;
      case (phase)
        PH_DATA: begin
          if (c == dpd_pkg::CH_ESCAPE) begin
            sum += c;
            phase = PH_ESC;
          end else if (c == dpd_pkg::CH_START) begin
            open_packet(ev);
            made = 1'b1;
          end else if (c == dpd_pkg::CH_END) begin
            phase = PH_CS1;
          end else begin
            sum += c;
            made = keep_payload(c, ev);
          end
        end
        PH_ESC: begin
          phase = PH_DATA;
          sum += c;
          made = keep_payload(c ^ dpd_pkg::ESC_XOR, ev);
        end
        PH_CS1: begin
          hi_nibble = {digit_value(c), 4'h0};
          phase = PH_CS2;
        end
        PH_CS2: begin
          rx = hi_nibble + {4'h0, digit_value(c)};
          phase = PH_HUNT;
          ev.len = stored[dpd_pkg::LEN_W-1:0];
          ev.csum = sum;
          ev.rsum = rx;
          if (rx == sum) begin
            good_count++;
            ev.kind = dpd_pkg::EV_GOOD;
            ev.pnum = good_count;
          end else begin
            ev.kind = dpd_pkg::EV_BAD;
          end
          made = 1'b1;
        end
        default: begin
          phase = PH_HUNT;
          if (c == dpd_pkg::CH_START) begin
            open_packet(ev);
            made = 1'b1;
          end else if (c == dpd_pkg::CH_BREAK) begin
            ev.kind = dpd_pkg::EV_BREAK;
            made = 1'b1;
          end
        end
      endcase
      if (made) owed_events.push_back(ev);
    endfunction

    function void report(input string what, input frame_event_t want,
                         input frame_event_t got);
      failures++;
      if (failures <= MAX_REPORTS)
        $display({"mismatch (%s): exp kind=%0d byte=%02h pos=%0d len=%0d",
                  " csum=%02h rsum=%02h pkt=%0d"},
                 what, want.kind, want.data, want.pos, want.len, want.csum, want.rsum,
                 want.pnum);
      if (failures <= MAX_REPORTS)
        $display({"                 got kind=%0d byte=%02h pos=%0d len=%0d",
                  " csum=%02h rsum=%02h pkt=%0d"},
                 got.kind, got.data, got.pos, got.len, got.csum, got.rsum, got.pnum);
    endfunction

    // Compare one accepted result with the oldest owed event
    function void match_event(input frame_event_t got);
      frame_event_t want;
      if (owed_events.size() == 0) begin
        want = '{default: 0};
        report("unexpected", want, got);
        return;
      end
      want = owed_events.pop_front();
      if (got.kind !== want.kind || got.data !== want.data || got.pos !== want.pos ||
          got.len !== want.len || got.csum !== want.csum || got.rsum !== want.rsum ||
          got.pnum !== want.pnum)
        report("field", want, got);
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_rx_byte = 8'h00;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [dpd_pkg::KIND_W-1:0] out_event_kind;
  logic [7:0]                 out_payload_byte;
  logic [dpd_pkg::POS_W-1:0]  out_byte_position;
  logic [dpd_pkg::LEN_W-1:0]  out_payload_length;
  logic [7:0]                 out_computed_sum;
  logic [7:0]                 out_received_sum;
  logic [dpd_pkg::PKT_W-1:0]  out_packet_number;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;

  deframe_tracker tracker = new();

  // Opening stream: break, ignored byte, escapes of framing characters, restart,
  // good ends with decimal and upper-case hex digits and a bad end with a non-hex digit
  logic [7:0] opening_bytes [] = '{
    dpd_pkg::CH_BREAK, "A",
    dpd_pkg::CH_START, 8'h00, 8'hFF, dpd_pkg::CH_ESCAPE, dpd_pkg::CH_START,
    dpd_pkg::CH_ESCAPE, dpd_pkg::CH_END,
    dpd_pkg::CH_START, "a", dpd_pkg::CH_END, "6", "1",
    dpd_pkg::CH_START, dpd_pkg::CH_ESCAPE, dpd_pkg::CH_ESCAPE, dpd_pkg::CH_END, "F", "A",
    dpd_pkg::CH_START, 8'h7E, dpd_pkg::CH_END, "G", "0",
    dpd_pkg::CH_BREAK
  };

  debug_packet_deframer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_kind     (out_event_kind),
    .out_payload_byte   (out_payload_byte),
    .out_byte_position  (out_byte_position),
    .out_payload_length (out_payload_length),
    .out_computed_sum   (out_computed_sum),
    .out_received_sum   (out_received_sum),
    .out_packet_number  (out_packet_number)
  );

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
      tracker.match_event('{out_event_kind, out_payload_byte, out_byte_position,
                            out_payload_length, out_computed_sum, out_received_sum,
                            out_packet_number});
  end

  // Pick a byte, biased toward framing characters and hex digits
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(11))
      0: return dpd_pkg::CH_START;
      1: return dpd_pkg::CH_END;
      2: return dpd_pkg::CH_ESCAPE;
      3: return dpd_pkg::CH_BREAK;
      4: return 8'($urandom_range("0", "9"));
      5: return 8'($urandom_range("a", "f"));
      6: return 8'($urandom_range("A", "F"));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return "0" + 8'(nib);
    return ($urandom_range(1) ? "A" : "a") + 8'(nib) - 8'd10;
  endfunction

  // Present one byte request and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(b);
    @(negedge clk);
  endtask

  // Send a framed packet with random content; most end with the right checksum.
  // A plain packet carries only bytes that need no escape.
  task automatic send_packet(input int unsigned min_len, input int unsigned max_len,
                             input bit plain);
    int unsigned n;
    int unsigned k;
    logic [7:0]  raw;
    logic [7:0]  sum;
    bit          esc;
    sum = 8'h00;
    send_byte(dpd_pkg::CH_START);
    n = $urandom_range(max_len, min_len);
    for (k = 0; k < n; k++) begin
      raw = plain ? 8'($urandom_range(8'h7C, 8'h25)) : pick_byte();
      esc = !plain && (raw == dpd_pkg::CH_START || raw == dpd_pkg::CH_END ||
                       raw == dpd_pkg::CH_ESCAPE || $urandom_range(9) == 0);
      if (esc) begin
        send_byte(dpd_pkg::CH_ESCAPE);
        send_byte(raw ^ dpd_pkg::ESC_XOR);
        sum += dpd_pkg::CH_ESCAPE + (raw ^ dpd_pkg::ESC_XOR);
      end else begin
        send_byte(raw);
        sum += raw;
      end
    end
    send_byte(dpd_pkg::CH_END);
    if ($urandom_range(99) < 85) begin
      send_byte(hex_char(sum[7:4]));
      send_byte(hex_char(sum[3:0]));
    end else begin
      send_byte(pick_byte());
      send_byte(pick_byte());
    end
  endtask

  // Send a run of loose bytes
  task automatic send_noise(input int unsigned max_len);
    int unsigned n;
    int unsigned k;
    n = $urandom_range(max_len, 1);
    for (k = 0; k < n; k++) send_byte(pick_byte());
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input bit with_long);
    int unsigned goal;
    int unsigned r;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    goal = tracker.used_bytes + PHASE_BYTES;
    if (with_long)
      send_packet(dpd_pkg::MAX_PAYLOAD + 2, dpd_pkg::MAX_PAYLOAD + 6, 1'b1);
    while (tracker.used_bytes < goal) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_noise(8);
      end else if (r < 15) begin
        // broken packet: opened, then cut off by the next one
        send_byte(dpd_pkg::CH_START);
        send_noise(6);
      end else begin
        send_packet(0, (r < 22) ? 40 : 10, 1'b0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    run_phase(27, 45, 1'b0);
    run_phase(45, 27, 1'b0);
    run_phase(0, 0, 1'b1);
    in_valid = 1'b0;

    // Drain the owed events, then let the pipeline settle
    while (tracker.owed_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.failures == 0 && tracker.owed_events.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/dpd_pkg.sv
src/dpd_parse.sv
src/debug_packet_deframer.sv
test/debug_packet_deframer_tb.sv
